### rtl/hss_pkg.sv
// Shared types and constants of the Hermite segment sampler.
// No dependencies; imported by every module of the block but hss_fifo.
package hss_pkg;

  localparam int CoordW  = 32;
  localparam int FracF   = 52 - CoordW;
  localparam int SlotW   = 2;
  localparam int CountW  = 7;
  localparam int SpeedW  = 16;
  localparam int TW      = 16;
  localparam int QuoW    = TW + 1;
  localparam int TanW    = CoordW + SpeedW + 2 - 8;
  localparam int BasisW  = FracF + 2;
  localparam int ExpW    = 52;
  localparam int DropW   = 48 - FracF;
  localparam int AccW    = BasisW + TanW + 2;
  localparam int JobDepth = 2;
  localparam int ResDepth = 2;

  localparam logic [SlotW-1:0] SlotLast = 2'd3;

  typedef logic signed [CoordW-1:0] coord_t;

  typedef struct packed {
    logic [SlotW-1:0]  slot;
    coord_t            pos_x;
    coord_t            pos_y;
    coord_t            pos_z;
    logic [CountW-1:0] sample_count;
    logic [SpeedW-1:0] speed;
  } hss_in_t;

  typedef struct packed {
    coord_t out_x;
    coord_t out_y;
    coord_t out_z;
    logic   last_sample;
  } hss_out_t;

  typedef struct packed {
    coord_t [11:0]     pts;
    logic [CountW-1:0] count;
    logic [SpeedW-1:0] speed;
  } hss_job_t;

endpackage

### rtl/hss_fifo.sv
// Small register queue with push/full and pop/empty sides.
// Depends on nothing; used for the job queue and the result queue.
module hss_fifo #(
  parameter type T = logic,
  parameter int DEPTH = 2
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  T     data_i,
  output logic full_o,
  input  logic pop_i,
  output T     data_o,
  output logic empty_o
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  T mem_q [DEPTH];
  logic [AW-1:0] wr_q, rd_q;
  logic [AW:0]   cnt_q;
  logic do_push, do_pop;

  assign full_o  = (cnt_q == (AW+1)'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == AW'(DEPTH-1)) ? '0 : wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= (rd_q == AW'(DEPTH-1)) ? '0 : rd_q + 1'b1;
      end
      cnt_q <= cnt_q + (AW+1)'(do_push) - (AW+1)'(do_pop);
    end
  end
endmodule

### rtl/hss_front.sv
// Front part: takes items, keeps control points P0..P2, forms a job on slot 3.
// Depends on hss_pkg.
module hss_front import hss_pkg::*; #(
  parameter int MAX_SAMPLES = 64
) (
  input  logic     clk_i,
  input  logic     push_i,
  input  hss_in_t  item_i,
  input  logic     job_full_i,
  output logic     full_o,
  output logic     job_push_o,
  output hss_job_t job_o
);
  coord_t pts_q [9];
  logic accept;
  logic [3:0] base;
  logic [CountW-1:0] n;

  assign full_o     = job_full_i;
  assign accept     = push_i && !job_full_i;
  assign job_push_o = accept && (item_i.slot == SlotLast);
  assign base       = 4'(item_i.slot) * 4'd3;

  always_comb begin
    if (item_i.sample_count == '0) begin
      n = CountW'(1);
    end else if (item_i.sample_count > CountW'(MAX_SAMPLES)) begin
      n = CountW'(MAX_SAMPLES);
    end else begin
      n = item_i.sample_count;
    end
    for (int i = 0; i < 9; i++) begin
      job_o.pts[i] = pts_q[i];
    end
    job_o.pts[9]  = item_i.pos_x;
    job_o.pts[10] = item_i.pos_y;
    job_o.pts[11] = item_i.pos_z;
    job_o.count   = n;
    job_o.speed   = item_i.speed;
  end

  always_ff @(posedge clk_i) begin
    if (accept && item_i.slot != SlotLast) begin
      pts_q[base]        <= item_i.pos_x;
      pts_q[base + 4'd1] <= item_i.pos_y;
      pts_q[base + 4'd2] <= item_i.pos_z;
    end
  end
endmodule

### rtl/hss_back.sv
// Back part: tangents, step divide, then per-sample basis and blend sequencer.
// Depends on hss_pkg.
module hss_back import hss_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     job_empty_i,
  input  hss_job_t job_i,
  output logic     job_pop_o,
  input  logic     res_full_i,
  output logic     res_push_o,
  output hss_out_t res_o
);
  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_TAN   = 8'b0000_0010,
    S_DIV   = 8'b0000_0100,
    S_SQ    = 8'b0000_1000,
    S_CUBE  = 8'b0001_0000,
    S_BASIS = 8'b0010_0000,
    S_MUL   = 8'b0100_0000,
    S_ACC   = 8'b1000_0000
  } state_e;

  localparam logic signed [AccW-1:0] SatMax =
    {{(AccW-CoordW+1){1'b0}}, {(CoordW-1){1'b1}}};
  localparam logic signed [AccW-1:0] SatMin =
    {{(AccW-CoordW+1){1'b1}}, {(CoordW-1){1'b0}}};

  state_e state_q, state_d;
  hss_job_t job_q;
  logic signed [TanW-1:0]   tan_q [6];
  logic signed [BasisW-1:0] h_q [4];
  logic signed [AccW-1:0]   prod_q [4];
  coord_t res_q [2];
  logic [2:0] j_q;
  logic [1:0] c_q;
  logic [4:0] bit_q;
  logic [CountW:0] rem_q;
  logic [QuoW-1:0] quo_q, q0_q, u_q;
  logic [CountW-1:0] r0_q, ur_q, k_q;
  logic [2*TW-1:0] uu_q;
  logic [3*TW-1:0] u3_q;

  logic signed [CoordW:0] diff;
  logic signed [CoordW+SpeedW+1:0] tprod;
  logic [CountW:0] remsh, rem_n, ur_sum;
  logic ge;
  logic [QuoW-1:0] quo_n;
  logic signed [ExpW-1:0] u3e, u2e, u1e, one, e00, e01, e10, e11;
  logic signed [BasisW+CoordW-1:0] pa, pb;
  logic signed [BasisW+TanW-1:0] pc, pd;
  logic signed [AccW-1:0] acc, shf;
  coord_t sat;
  logic last;
  logic [3:0] ia, ib;

  assign ia = 4'(j_q) + 4'd6;
  assign diff = $signed({job_q.pts[ia][CoordW-1], job_q.pts[ia]})
              - $signed({job_q.pts[4'(j_q)][CoordW-1], job_q.pts[4'(j_q)]});
  assign tprod = diff * $signed({1'b0, job_q.speed});

  assign remsh = {rem_q[CountW-1:0], (bit_q == 5'd16)};
  assign ge    = remsh >= {1'b0, job_q.count};
  assign rem_n = ge ? remsh - {1'b0, job_q.count} : remsh;
  assign quo_n = {quo_q[QuoW-2:0], ge};
  assign ur_sum = {1'b0, ur_q} + {1'b0, r0_q};

  assign u3e = ExpW'(u3_q);
  assign u2e = ExpW'({uu_q, {TW{1'b0}}});
  assign u1e = ExpW'({u_q[TW-1:0], {(2*TW){1'b0}}});
  assign one = ExpW'(1) <<< 48;
  assign e00 = (u3e <<< 1) - (u2e <<< 1) - u2e + one;
  assign e01 = (u2e <<< 1) + u2e - (u3e <<< 1);
  assign e10 = u3e - (u2e <<< 1) + u1e;
  assign e11 = u3e - u2e;

  assign ib = 4'(c_q) + 4'd3;
  assign pa = h_q[0] * job_q.pts[4'(c_q)];
  assign pb = h_q[1] * job_q.pts[ib];
  assign pc = h_q[2] * tan_q[3'(c_q)];
  assign pd = h_q[3] * tan_q[3'(c_q) + 3'd3];

  assign acc = prod_q[0] + prod_q[1] + prod_q[2] + prod_q[3];
  assign shf = acc >>> FracF;
  assign sat = (shf > SatMax) ? CoordW'(SatMax) :
               (shf < SatMin) ? CoordW'(SatMin) : CoordW'(shf);
  assign last = (k_q == job_q.count - CountW'(1));

  assign res_o.out_x = res_q[0];
  assign res_o.out_y = res_q[1];
  assign res_o.out_z = sat;
  assign res_o.last_sample = last;

  always_comb begin
    state_d    = state_q;
    job_pop_o  = 1'b0;
    res_push_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (!job_empty_i) begin
          job_pop_o = 1'b1;
          state_d   = S_TAN;
        end
      end
      S_TAN: begin
        if (j_q == 3'd5) state_d = S_DIV;
      end
      S_DIV: begin
        if (bit_q == '0) state_d = S_SQ;
      end
      S_SQ: begin
        if (!res_full_i) state_d = S_CUBE;
      end
      S_CUBE:  state_d = S_BASIS;
      S_BASIS: state_d = S_MUL;
      S_MUL:   state_d = S_ACC;
      S_ACC: begin
        if (c_q == 2'd2) begin
          res_push_o = 1'b1;
          state_d    = last ? S_IDLE : S_SQ;
        end else begin
          state_d = S_MUL;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        job_q <= job_i;
        j_q   <= '0;
      end
      S_TAN: begin
        tan_q[j_q] <= TanW'(tprod >>> 8);
        j_q   <= j_q + 3'd1;
        rem_q <= '0;
        quo_q <= '0;
        bit_q <= 5'd16;
      end
      S_DIV: begin
        rem_q <= rem_n;
        quo_q <= quo_n;
        bit_q <= bit_q - 5'd1;
        q0_q  <= quo_n;
        r0_q  <= rem_n[CountW-1:0];
        u_q   <= '0;
        ur_q  <= '0;
        k_q   <= '0;
        c_q   <= '0;
      end
      S_SQ: uu_q <= u_q[TW-1:0] * u_q[TW-1:0];
      S_CUBE: u3_q <= uu_q * u_q[TW-1:0];
      S_BASIS: begin
        h_q[0] <= BasisW'(e00 >>> DropW);
        h_q[1] <= BasisW'(e01 >>> DropW);
        h_q[2] <= BasisW'(e10 >>> DropW);
        h_q[3] <= BasisW'(e11 >>> DropW);
      end
      S_MUL: begin
        prod_q[0] <= AccW'(pa);
        prod_q[1] <= AccW'(pb);
        prod_q[2] <= AccW'(pc);
        prod_q[3] <= AccW'(pd);
      end
      S_ACC: begin
        if (c_q == 2'd2) begin
          c_q <= '0;
          k_q <= k_q + CountW'(1);
          if (ur_sum >= {1'b0, job_q.count}) begin
            ur_q <= CountW'(ur_sum - {1'b0, job_q.count});
            u_q  <= u_q + q0_q + QuoW'(1);
          end else begin
            ur_q <= ur_sum[CountW-1:0];
            u_q  <= u_q + q0_q;
          end
        end else begin
          res_q[c_q[0]] <= sat;
          c_q <= c_q + 2'd1;
        end
      end
      default: ;
    endcase
  end
endmodule

### rtl/hermite_segment_sampler_unit.sv
// Hermite segment sampler: takes four control points, emits sampled curve points.
// Depends on hss_pkg, hss_front, hss_fifo, hss_back.
//
// Input queue side: push/full. Items tagged slot 0..2 store P0..P2, produce
// nothing and are taken one per cycle while full is low. A slot-3 item
// carries P3, sample_count and speed and becomes a job in a two-entry job queue.
// Result queue side: empty/pop. One result per sample, oldest first; the
// final sample of a segment has last_sample set.
// Per segment the back end loads the job, computes six tangents (one shared
// 33x17 multiply per cycle), does the t step divide (one quotient bit per
// cycle), then per sample works through square, cube, basis and three
// multiply/accumulate pairs, one per coordinate.
// Results pass through a two-entry queue; when it is full the back end
// waits before starting the next sample, and the job queue lets up to two
// more segments be taken meanwhile. full rises only when the job queue is.
// Reset empties both queues and idles the back end; stored control points
// are not cleared.
module hermite_segment_sampler_unit import hss_pkg::*; #(
  parameter int MAX_SAMPLES = 64
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push,
  output logic     full,
  input  hss_in_t  in_item_i,
  output logic     empty,
  input  logic     pop,
  output hss_out_t out_item_o
);
  logic job_full, job_push, job_empty, job_pop, res_full, res_push;
  hss_job_t job_in, job_out;
  hss_out_t res;

  hss_front #(.MAX_SAMPLES(MAX_SAMPLES)) u_front (
    .clk_i      (clk_i),
    .push_i     (push),
    .item_i     (in_item_i),
    .job_full_i (job_full),
    .full_o     (full),
    .job_push_o (job_push),
    .job_o      (job_in)
  );

  hss_fifo #(.T(hss_job_t), .DEPTH(JobDepth)) u_job_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (job_push),
    .data_i  (job_in),
    .full_o  (job_full),
    .pop_i   (job_pop),
    .data_o  (job_out),
    .empty_o (job_empty)
  );

  hss_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_empty_i (job_empty),
    .job_i       (job_out),
    .job_pop_o   (job_pop),
    .res_full_i  (res_full),
    .res_push_o  (res_push),
    .res_o       (res)
  );

  hss_fifo #(.T(hss_out_t), .DEPTH(ResDepth)) u_res_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res),
    .full_o  (res_full),
    .pop_i   (pop),
    .data_o  (out_item_o),
    .empty_o (empty)
  );
endmodule

### rtl/hss_checker.sv
// Port-level checks for the Hermite segment sampler, bound to the top level.
// Depends on hss_pkg and hermite_segment_sampler_unit.
module hss_port_checks import hss_pkg::*; (
  input logic     clk_i,
  input logic     rst_ni,
  input logic     push,
  input logic     full,
  input hss_in_t  in_item_i,
  input logic     empty,
  input logic     pop,
  input hss_out_t out_item_o
);
  logic [7:0] open_q;
  logic seg_in, seg_out;

  assign seg_in  = push && !full && (in_item_i.slot == SlotLast);
  assign seg_out = pop && !empty && out_item_o.last_sample;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q <= '0;
    end else begin
      open_q <= open_q + 8'(seg_in) - 8'(seg_out);
    end
  end

  a_reset_empty: assert property (@(posedge clk_i)
    !rst_ni && $past(!rst_ni) |-> empty && !full)
    else $error("queues not empty in reset");

  a_no_open_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    open_q == '0 |-> empty)
    else $error("result without open segment");

  a_last_has_seg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    seg_out |-> (open_q != '0) || seg_in)
    else $error("segment end without segment");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !pop |=> !empty && $stable(out_item_o))
    else $error("stalled result changed");
endmodule

bind hermite_segment_sampler_unit hss_port_checks u_hss_port_checks (.*);
